// File: sv/awbg_pkg.sv
// Shared types and constants for the white-balance gain pipeline.
// Standalone package with no dependencies; used by awb_gain_from_otp_ratios_unit.
package awbg_pkg;

	// Field widths
	localparam int RATIO_W   = 16;
	localparam int GAIN_W    = 12;
	localparam int Q1_W      = 24;             // 256 * ratio / ratio, full precision
	localparam int Q2_W      = GAIN_W;         // second quotient, saturated separately
	localparam int PROD_W    = Q1_W + RATIO_W; // green gain times golden ratio
	localparam int STEP_BITS = 4;              // quotient bits resolved per stage
	localparam int D1_STEPS  = Q1_W / STEP_BITS;
	localparam int D2_STEPS  = Q2_W / STEP_BITS;
	localparam int CFG_IDX_W = 1;

	// Gain limits, 4.8 form
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 12'h100;
	localparam logic [GAIN_W-1:0] GAIN_MAX   = 12'hFFF;

	// Golden ratio reset values
	localparam logic [RATIO_W-1:0] RG_GOLDEN_RESET = 16'h0275;
	localparam logic [RATIO_W-1:0] BG_GOLDEN_RESET = 16'h0269;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RG_GOLDEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BG_GOLDEN = 1'b1;

	// Which gain the second division produces
	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_RED  = 2'd1,
		TGT_BLUE = 2'd2
	} fill_tgt_t;

	typedef struct packed {
		logic [RATIO_W-1:0] r_over_g;
		logic [RATIO_W-1:0] b_over_g;
	} awbg_in_t;

	typedef struct packed {
		logic [GAIN_W-1:0] red_gain;
		logic [GAIN_W-1:0] green_gain;
		logic [GAIN_W-1:0] blue_gain;
		logic              divide_error;
	} awbg_out_t;

	// Restoring divider state: partial remainder and numerator/quotient shift word
	typedef struct packed {
		logic [RATIO_W-1:0] rem;
		logic [Q1_W-1:0]    nq;
	} div1_t;

	typedef struct packed {
		logic [RATIO_W-1:0] rem;
		logic [Q2_W-1:0]    nq;
	} div2_t;

	// Operands carried along the first division
	typedef struct packed {
		logic [RATIO_W-1:0] r;
		logic [RATIO_W-1:0] b;
		logic [RATIO_W-1:0] rg;
		logic [RATIO_W-1:0] bg;
		logic [RATIO_W-1:0] den_a;
		logic [RATIO_W-1:0] den_b;
		logic               b_lt;
		logic               r_lt;
		logic               err;
	} side_t;

	// Gains already settled before the second division
	typedef struct packed {
		logic [GAIN_W-1:0] r_fix;
		logic [GAIN_W-1:0] g_fix;
		logic [GAIN_W-1:0] b_fix;
		fill_tgt_t         tgt;
		logic              err;
	} fin_t;

	// Clamp below at unity, saturate above at the 12-bit maximum
	function automatic logic [GAIN_W-1:0] fit_gain(input logic [Q1_W-1:0] g);
		logic [GAIN_W-1:0] res;
		if (g < Q1_W'(UNITY_GAIN)) begin
			res = UNITY_GAIN;
		end else if (g > Q1_W'(GAIN_MAX)) begin
			res = GAIN_MAX;
		end else begin
			res = g[GAIN_W-1:0];
		end
		return res;
	endfunction

endpackage

// File: sv/awb_gain_from_otp_ratios_unit.sv
// White-balance gain pipeline: golden ratio registers, two 24-bit dividers,
// a 24x16 multiplier and a 12-bit saturating divider. Depends on awbg_pkg.

// Turns a module's measured R/G and B/G ratios into red, green and blue
// gains in 4.8 form against the golden ratios held in two registers. The
// channel that needs the least gain gets exactly 0x100; the others come from
// truncating ratio divisions, clamped to 0x100..0xFFF. A zero divisor in the
// chosen path returns unity gains with divide_error set. The block is a
// fourteen-stage pipeline: it takes one transfer per clock when the output
// is not stalled. Most stages go to the first division pair (six stages of
// four quotient bits) and the chained second division (multiply, range
// check, three stages). Bubbles close up while the output is stalled.
module awb_gain_from_otp_ratios_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  awbg_pkg::awbg_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output awbg_pkg::awbg_out_t                 out_data,
	input  logic                                cfg_we,
	input  logic [awbg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [awbg_pkg::RATIO_W-1:0]        cfg_data
);

	localparam int ST_DIV1 = 2;
	localparam int ST_SEL  = ST_DIV1 + awbg_pkg::D1_STEPS;
	localparam int ST_MUL  = ST_SEL + 1;
	localparam int ST_OVF  = ST_MUL + 1;
	localparam int ST_DIV2 = ST_OVF + 1;
	localparam int ST_OUT  = ST_DIV2 + awbg_pkg::D2_STEPS;

	// Four restoring steps over the 24-bit numerator word
	function automatic awbg_pkg::div1_t div1_step(input awbg_pkg::div1_t d,
			input logic [awbg_pkg::RATIO_W-1:0] den);
		logic [awbg_pkg::RATIO_W:0]   t;
		logic [awbg_pkg::RATIO_W-1:0] r;
		logic [awbg_pkg::Q1_W-1:0]    x;
		awbg_pkg::div1_t              res;
		r = d.rem;
		x = d.nq;
		for (int i = 0; i < awbg_pkg::STEP_BITS; i++) begin
			t = {r, x[awbg_pkg::Q1_W-1]};
			x = {x[awbg_pkg::Q1_W-2:0], 1'b0};
			if (t >= {1'b0, den}) begin
				t    = t - {1'b0, den};
				x[0] = 1'b1;
			end
			r = t[awbg_pkg::RATIO_W-1:0];
		end
		res.rem = r;
		res.nq  = x;
		return res;
	endfunction

	// Four restoring steps over the 12-bit low word
	function automatic awbg_pkg::div2_t div2_step(input awbg_pkg::div2_t d,
			input logic [awbg_pkg::RATIO_W-1:0] den);
		logic [awbg_pkg::RATIO_W:0]   t;
		logic [awbg_pkg::RATIO_W-1:0] r;
		logic [awbg_pkg::Q2_W-1:0]    x;
		awbg_pkg::div2_t              res;
		r = d.rem;
		x = d.nq;
		for (int i = 0; i < awbg_pkg::STEP_BITS; i++) begin
			t = {r, x[awbg_pkg::Q2_W-1]};
			x = {x[awbg_pkg::Q2_W-2:0], 1'b0};
			if (t >= {1'b0, den}) begin
				t    = t - {1'b0, den};
				x[0] = 1'b1;
			end
			r = t[awbg_pkg::RATIO_W-1:0];
		end
		res.rem = r;
		res.nq  = x;
		return res;
	endfunction

	// Golden ratio registers
	logic [awbg_pkg::RATIO_W-1:0] rg_golden_q;
	logic [awbg_pkg::RATIO_W-1:0] bg_golden_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rg_golden_q <= awbg_pkg::RG_GOLDEN_RESET;
			bg_golden_q <= awbg_pkg::BG_GOLDEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				awbg_pkg::REG_RG_GOLDEN: rg_golden_q <= cfg_data;
				awbg_pkg::REG_BG_GOLDEN: bg_golden_q <= cfg_data;
			endcase
		end
	end

	// Valid bits and the ready chain; a stage loads when empty or moving on
	logic [ST_OUT:1] valid_s;
	logic [ST_OUT:1] rdy;
	logic [ST_OUT:1] vprev;

	assign vprev = {valid_s[ST_OUT-1:1], in_valid};

	always_comb begin
		rdy[ST_OUT] = !valid_s[ST_OUT] || !out_stall;
		for (int i = ST_OUT - 1; i >= 1; i--) begin
			rdy[i] = !valid_s[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int i = 1; i <= ST_OUT; i++) begin
				if (rdy[i]) begin
					valid_s[i] <= vprev[i];
				end
			end
		end
	end

	assign in_stall  = !rdy[1];
	assign out_valid = valid_s[ST_OUT];

	// Stage 1: decode the case, pick divider operands, flag zero divisors
	logic                         b_lt;
	logic                         r_lt;
	logic                         pair_case;
	logic                         err_in;
	awbg_pkg::side_t              side_in;

	always_comb begin
		b_lt      = in_data.b_over_g < bg_golden_q;
		r_lt      = in_data.r_over_g < rg_golden_q;
		pair_case = b_lt && r_lt;
		unique case ({b_lt, r_lt})
			2'b11:   err_in = (in_data.b_over_g == '0) || (in_data.r_over_g == '0);
			2'b10:   err_in = (rg_golden_q == '0) || (in_data.b_over_g == '0);
			2'b01:   err_in = (bg_golden_q == '0) || (in_data.r_over_g == '0);
			default: err_in = (bg_golden_q == '0) || (rg_golden_q == '0);
		endcase
		side_in.r     = in_data.r_over_g;
		side_in.b     = in_data.b_over_g;
		side_in.rg    = rg_golden_q;
		side_in.bg    = bg_golden_q;
		side_in.den_a = pair_case ? in_data.b_over_g : bg_golden_q;
		side_in.den_b = pair_case ? in_data.r_over_g : rg_golden_q;
		side_in.b_lt  = b_lt;
		side_in.r_lt  = r_lt;
		side_in.err   = err_in;
	end

	awbg_pkg::div1_t div_a_s [0:awbg_pkg::D1_STEPS];
	awbg_pkg::div1_t div_b_s [0:awbg_pkg::D1_STEPS];
	awbg_pkg::side_t side_s  [0:awbg_pkg::D1_STEPS];

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			div_a_s[0].rem <= '0;
			div_a_s[0].nq  <= {(pair_case ? bg_golden_q : in_data.b_over_g), 8'h00};
			div_b_s[0].rem <= '0;
			div_b_s[0].nq  <= {(pair_case ? rg_golden_q : in_data.r_over_g), 8'h00};
			side_s[0]      <= side_in;
		end
	end

	// Stages 2..7: both first divisions, four quotient bits per stage
	for (genvar k = 0; k < awbg_pkg::D1_STEPS; k++) begin : g_div1
		always_ff @(posedge clk) begin
			if (rdy[ST_DIV1+k]) begin
				div_a_s[k+1] <= div1_step(div_a_s[k], side_s[k].den_a);
				div_b_s[k+1] <= div1_step(div_b_s[k], side_s[k].den_b);
				side_s[k+1]  <= side_s[k];
			end
		end
	end

	// Stage 8: choose the reference channel and set up the chained division
	localparam logic [awbg_pkg::Q1_W-1:0] Q1W_UNITY = awbg_pkg::Q1_W'(awbg_pkg::UNITY_GAIN);

	logic [awbg_pkg::Q1_W-1:0]    qa;
	logic [awbg_pkg::Q1_W-1:0]    qb;
	logic [awbg_pkg::Q1_W-1:0]    gg_sel;
	logic [awbg_pkg::RATIO_W-1:0] mgold_sel;
	logic [awbg_pkg::RATIO_W-1:0] den2_sel;
	awbg_pkg::fin_t               fin_sel;
	awbg_pkg::side_t              sd;

	always_comb begin
		qa          = div_a_s[awbg_pkg::D1_STEPS].nq;
		qb          = div_b_s[awbg_pkg::D1_STEPS].nq;
		sd          = side_s[awbg_pkg::D1_STEPS];
		gg_sel      = qb;
		mgold_sel   = sd.bg;
		den2_sel    = sd.b;
		fin_sel.err = sd.err;
		fin_sel.r_fix = awbg_pkg::UNITY_GAIN;
		fin_sel.b_fix = awbg_pkg::UNITY_GAIN;
		fin_sel.tgt   = awbg_pkg::TGT_BLUE;
		unique case ({sd.b_lt, sd.r_lt})
			2'b11: begin
				gg_sel        = Q1W_UNITY;
				fin_sel.tgt   = awbg_pkg::TGT_NONE;
				fin_sel.r_fix = awbg_pkg::fit_gain(qb);
				fin_sel.b_fix = awbg_pkg::fit_gain(qa);
			end
			2'b10: begin
				gg_sel = qb;
			end
			2'b01: begin
				gg_sel      = qa;
				mgold_sel   = sd.rg;
				den2_sel    = sd.r;
				fin_sel.tgt = awbg_pkg::TGT_RED;
			end
			default: begin
				if (qa > qb) begin
					gg_sel      = qa;
					mgold_sel   = sd.rg;
					den2_sel    = sd.r;
					fin_sel.tgt = awbg_pkg::TGT_RED;
				end
			end
		endcase
		fin_sel.g_fix = awbg_pkg::fit_gain(gg_sel);
	end

	logic [awbg_pkg::Q1_W-1:0]    gg_s8;
	logic [awbg_pkg::RATIO_W-1:0] mgold_s8;
	logic [awbg_pkg::RATIO_W-1:0] den2_s8;
	awbg_pkg::fin_t               fin_s8;

	always_ff @(posedge clk) begin
		if (rdy[ST_SEL]) begin
			gg_s8    <= gg_sel;
			mgold_s8 <= mgold_sel;
			den2_s8  <= den2_sel;
			fin_s8   <= fin_sel;
		end
	end

	// Stage 9: green gain times golden ratio
	logic [awbg_pkg::PROD_W-1:0]  prod_s9;
	logic [awbg_pkg::RATIO_W-1:0] den2_s9;
	awbg_pkg::fin_t               fin_s9;

	always_ff @(posedge clk) begin
		if (rdy[ST_MUL]) begin
			prod_s9 <= {{awbg_pkg::RATIO_W{1'b0}}, gg_s8} *
				{{awbg_pkg::Q1_W{1'b0}}, mgold_s8};
			den2_s9 <= den2_s8;
			fin_s9  <= fin_s8;
		end
	end

	// Stage 10: detect a quotient past 12 bits, seed the remainder with the high part
	awbg_pkg::div2_t              div2_s [0:awbg_pkg::D2_STEPS];
	logic [awbg_pkg::RATIO_W-1:0] den2_s [0:awbg_pkg::D2_STEPS];
	awbg_pkg::fin_t               fin_s  [0:awbg_pkg::D2_STEPS];
	logic                         ovf_s  [0:awbg_pkg::D2_STEPS];

	always_ff @(posedge clk) begin
		if (rdy[ST_OVF]) begin
			ovf_s[0] <= prod_s9[awbg_pkg::PROD_W-1:awbg_pkg::Q2_W] >=
				(awbg_pkg::PROD_W - awbg_pkg::Q2_W)'(den2_s9);
			div2_s[0].rem <= prod_s9[awbg_pkg::Q2_W+awbg_pkg::RATIO_W-1:awbg_pkg::Q2_W];
			div2_s[0].nq  <= prod_s9[awbg_pkg::Q2_W-1:0];
			den2_s[0]     <= den2_s9;
			fin_s[0]      <= fin_s9;
		end
	end

	// Stages 11..13: second division, four quotient bits per stage
	for (genvar k = 0; k < awbg_pkg::D2_STEPS; k++) begin : g_div2
		always_ff @(posedge clk) begin
			if (rdy[ST_DIV2+k]) begin
				div2_s[k+1] <= div2_step(div2_s[k], den2_s[k]);
				den2_s[k+1] <= den2_s[k];
				fin_s[k+1]  <= fin_s[k];
				ovf_s[k+1]  <= ovf_s[k];
			end
		end
	end

	// Stage 14: drop the chained gain into place, apply the error override
	logic [awbg_pkg::GAIN_W-1:0] q2_fit;
	awbg_pkg::fin_t              fl;
	awbg_pkg::awbg_out_t         res;
	awbg_pkg::awbg_out_t         out_s14;

	always_comb begin
		fl     = fin_s[awbg_pkg::D2_STEPS];
		q2_fit = ovf_s[awbg_pkg::D2_STEPS] ? awbg_pkg::GAIN_MAX :
			awbg_pkg::fit_gain(awbg_pkg::Q1_W'(div2_s[awbg_pkg::D2_STEPS].nq));
		res.red_gain     = fl.r_fix;
		res.green_gain   = fl.g_fix;
		res.blue_gain    = fl.b_fix;
		res.divide_error = fl.err;
		unique case (fl.tgt)
			awbg_pkg::TGT_RED:  res.red_gain  = q2_fit;
			awbg_pkg::TGT_BLUE: res.blue_gain = q2_fit;
			default: ;
		endcase
		if (fl.err) begin
			res.red_gain   = awbg_pkg::UNITY_GAIN;
			res.green_gain = awbg_pkg::UNITY_GAIN;
			res.blue_gain  = awbg_pkg::UNITY_GAIN;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_OUT]) begin
			out_s14 <= res;
		end
	end

	assign out_data = out_s14;

`ifndef ASSERT_OFF
	// An error result carries unity on every channel
	a_err_unity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_error |->
			out_data.red_gain == awbg_pkg::UNITY_GAIN &&
			out_data.green_gain == awbg_pkg::UNITY_GAIN &&
			out_data.blue_gain == awbg_pkg::UNITY_GAIN)
		else $error("error result with non-unity gain");

	// The reference channel always lands on exact unity
	a_ref_unity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			out_data.red_gain == awbg_pkg::UNITY_GAIN ||
			out_data.green_gain == awbg_pkg::UNITY_GAIN ||
			out_data.blue_gain == awbg_pkg::UNITY_GAIN)
		else $error("no channel at unity gain");

	// Gains never fall below unity
	a_gain_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			out_data.red_gain >= awbg_pkg::UNITY_GAIN &&
			out_data.green_gain >= awbg_pkg::UNITY_GAIN &&
			out_data.blue_gain >= awbg_pkg::UNITY_GAIN)
		else $error("gain below unity");

	// An empty first stage never holds off the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s[1] |-> !in_stall)
		else $error("input stalled with empty first stage");

	// A chained red gain leaves blue at unity
	a_red_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[ST_MUL] && fin_s9.tgt == awbg_pkg::TGT_RED |->
			fin_s9.b_fix == awbg_pkg::UNITY_GAIN)
		else $error("red chained gain without unity blue");
`endif

endmodule

// File: tb/awbg_checker.sv
// Checker for the white-balance gain unit. It watches the input, output and config ports,
// predicts the gains of each accepted transfer and compares them. Depends on awbg_pkg.
module awbg_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  awbg_pkg::awbg_in_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  awbg_pkg::awbg_out_t            out_data,
	input  logic                           cfg_we,
	input  logic [awbg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [awbg_pkg::RATIO_W-1:0]   cfg_data,
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 200;

	logic [awbg_pkg::RATIO_W-1:0] rg_golden = awbg_pkg::RG_GOLDEN_RESET;
	logic [awbg_pkg::RATIO_W-1:0] bg_golden = awbg_pkg::BG_GOLDEN_RESET;
	awbg_pkg::awbg_out_t gains_due[$];
	int mismatch_cnt = 0;

	assign errors = mismatch_cnt;

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= PRINT_CAP) begin
			$display("%0t: gain mismatch: %s", $time, msg);
		end
	endtask

	// Truncating division; a zero divisor is flagged by the caller
	function automatic longint unsigned ratio_div(input longint unsigned num,
			input longint unsigned den);
		if (den == 0) begin
			return 0;
		end
		return num / den;
	endfunction

	// Clamp below at unity, saturate at the 12-bit maximum
	function automatic logic [awbg_pkg::GAIN_W-1:0] clamp_gain(input longint unsigned g);
		if (g < awbg_pkg::UNITY_GAIN) begin
			return awbg_pkg::UNITY_GAIN;
		end
		if (g > awbg_pkg::GAIN_MAX) begin
			return awbg_pkg::GAIN_MAX;
		end
		return awbg_pkg::GAIN_W'(g);
	endfunction

	// Pick the channel needing least gain, give it unity, scale the other two
	function automatic awbg_pkg::awbg_out_t predict_gains(input awbg_pkg::awbg_in_t it,
			input logic [awbg_pkg::RATIO_W-1:0] rg_g,
			input logic [awbg_pkg::RATIO_W-1:0] bg_g);
		longint unsigned r, b, rg, bg, unity, gr, gg, gb, cand_b, cand_r;
		bit zero_den;
		awbg_pkg::awbg_out_t res;
		r = it.r_over_g;
		b = it.b_over_g;
		rg = rg_g;
		bg = bg_g;
		unity = awbg_pkg::UNITY_GAIN;
		if (b < bg && r < rg) begin
			zero_den = (b == 0) || (r == 0);
			gg = unity;
			gb = ratio_div(unity * bg, b);
			gr = ratio_div(unity * rg, r);
		end else if (b < bg) begin
			// green gain feeds the blue division at full precision
			zero_den = (rg == 0) || (b == 0);
			gr = unity;
			gg = ratio_div(unity * r, rg);
			gb = ratio_div(gg * bg, b);
		end else if (r < rg) begin
			zero_den = (bg == 0) || (r == 0);
			gb = unity;
			gg = ratio_div(unity * b, bg);
			gr = ratio_div(gg * rg, r);
		end else begin
			// both at or above golden: the larger green candidate wins, ties go to red
			cand_b = ratio_div(b * unity, bg);
			cand_r = ratio_div(r * unity, rg);
			if (cand_b > cand_r) begin
				zero_den = (bg == 0) || (rg == 0) || (r == 0);
				gb = unity;
				gg = cand_b;
				gr = ratio_div(cand_b * rg, r);
			end else begin
				zero_den = (bg == 0) || (rg == 0) || (b == 0);
				gr = unity;
				gg = cand_r;
				gb = ratio_div(cand_r * bg, b);
			end
		end
		if (zero_den) begin
			gr = unity;
			gg = unity;
			gb = unity;
		end
		res.red_gain = clamp_gain(gr);
		res.green_gain = clamp_gain(gg);
		res.blue_gain = clamp_gain(gb);
		res.divide_error = zero_den;
		return res;
	endfunction

	// Track config, queue predictions, compare each result transfer
	always @(posedge clk) begin
		awbg_pkg::awbg_out_t want;
		if (!arst_n) begin
			rg_golden <= awbg_pkg::RG_GOLDEN_RESET;
			bg_golden <= awbg_pkg::BG_GOLDEN_RESET;
			gains_due.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (gains_due.size() == 0) begin
					report_mismatch("result transfer with no input waiting");
				end else begin
					want = gains_due.pop_front();
					if (out_data.red_gain !== want.red_gain) begin
						report_mismatch($sformatf("red_gain got %0d expected %0d",
							out_data.red_gain, want.red_gain));
					end
					if (out_data.green_gain !== want.green_gain) begin
						report_mismatch($sformatf("green_gain got %0d expected %0d",
							out_data.green_gain, want.green_gain));
					end
					if (out_data.blue_gain !== want.blue_gain) begin
						report_mismatch($sformatf("blue_gain got %0d expected %0d",
							out_data.blue_gain, want.blue_gain));
					end
					if (out_data.divide_error !== want.divide_error) begin
						report_mismatch($sformatf("divide_error got %0b expected %0b",
							out_data.divide_error, want.divide_error));
					end
				end
			end
			if (in_valid && !in_stall) begin
				gains_due.push_back(predict_gains(in_data, rg_golden, bg_golden));
			end
			if (cfg_we) begin
				case (cfg_index)
					awbg_pkg::REG_RG_GOLDEN: begin
						rg_golden <= cfg_data;
					end
					awbg_pkg::REG_BG_GOLDEN: begin
						bg_golden <= cfg_data;
					end
					default: ;
				endcase
			end
			pending <= gains_due.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the white-balance gain testbench: clock, reset, stimulus, config phases and the
// verdict. Instantiates awb_gain_from_otp_ratios_unit and awbg_checker; uses awbg_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD  = 5;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PRESS_CYCLES = 60;
	localparam int PRESS_ITEMS  = 80;
	localparam int PER_PHASE    = 215;
	localparam int N_PHASES     = 8;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	awbg_pkg::awbg_in_t             in_data = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	awbg_pkg::awbg_out_t            out_data;
	logic                           cfg_we = 1'b0;
	logic [awbg_pkg::CFG_IDX_W-1:0] cfg_index = awbg_pkg::REG_RG_GOLDEN;
	logic [awbg_pkg::RATIO_W-1:0]   cfg_data = '0;

	int gain_errors;
	int gains_pending;
	bit no_idle = 1'b0;
	bit press_req = 1'b0;
	int tx_mood = 0;
	bit tx_idle_ok = 1'b0;
	int stuck_cycles = 0;

	always #(HALF_PERIOD) clk = ~clk;

	awb_gain_from_otp_ratios_unit dut (.*);

	awbg_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (gain_errors),
		.pending   (gains_pending)
	);

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
		if (stuck_cycles >= IDLE_LIMIT) begin
			$display("[awb_gain_from_otp_ratios_unit] ERROR");
			$finish;
		end
	end

	// Result side: random stall bursts in calm and busy stretches, plus one long hold-off
	initial begin : drain_side
		int hold, mood;
		bit idle_ok, press_done;
		hold = 0;
		mood = 0;
		idle_ok = 1'b0;
		press_done = 1'b0;
		forever begin
			@(posedge clk);
			if (mood == 0) begin
				idle_ok = ($urandom_range(0, 2) != 0);
				mood = $urandom_range(20, 150);
			end
			mood--;
			if (hold == 0) begin
				if (press_req && !press_done) begin
					press_done = 1'b1;
					hold = PRESS_CYCLES;
				end else if (!no_idle && idle_ok && $urandom_range(0, 5) == 0) begin
					hold = $urandom_range(1, 19);
				end
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one ratio pair, with an optional idle burst first; return once accepted
	task automatic put_pair(input logic [awbg_pkg::RATIO_W-1:0] r,
			input logic [awbg_pkg::RATIO_W-1:0] b, input bit may_gap);
		if (tx_mood == 0) begin
			tx_idle_ok = ($urandom_range(0, 2) != 0);
			tx_mood = $urandom_range(20, 120);
		end
		tx_mood--;
		if (may_gap && tx_idle_ok && !no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= awbg_pkg::awbg_in_t'{r_over_g: r, b_over_g: b};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drop valid, wait for every result, then let the pipeline drain
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (gains_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Ratio biased toward the golden value, small and large corners and bit flips
	function automatic logic [awbg_pkg::RATIO_W-1:0] pick_ratio(
			input logic [awbg_pkg::RATIO_W-1:0] golden);
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				v = $urandom_range(0, 65535);
			end
			3, 4, 5: begin
				v = int'(golden) + $urandom_range(0, 16) - 8;
			end
			6: begin
				v = $urandom_range(0, 15);
			end
			7: begin
				v = $urandom_range(65280, 65535);
			end
			8: begin
				v = (int'(golden) * $urandom_range(1, 24)) >> $urandom_range(0, 4);
			end
			default: begin
				v = int'(golden) ^ (1 << $urandom_range(0, 15));
			end
		endcase
		if (v < 0) begin
			v = 0;
		end
		if (v > 65535) begin
			v = 65535;
		end
		return awbg_pkg::RATIO_W'(v);
	endfunction

	initial begin : stimulus
		logic [awbg_pkg::RATIO_W-1:0] cur_rg, cur_bg;
		int n, phase;
		cur_rg = awbg_pkg::RG_GOLDEN_RESET;
		cur_bg = awbg_pkg::BG_GOLDEN_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners against the reset goldens
		put_pair(16'd0, 16'd0, 1'b1);           // zero divisor, both below golden
		put_pair(16'd0, 16'd700, 1'b1);         // zero red ratio, blue above
		put_pair(16'd700, 16'd0, 1'b1);         // zero blue ratio, red above
		put_pair(16'hFFFF, 16'd0, 1'b1);
		put_pair(16'd0, 16'hFFFF, 1'b1);
		put_pair(16'd1, 16'd1, 1'b1);           // huge gains saturate
		put_pair(awbg_pkg::RG_GOLDEN_RESET - 16'd1, awbg_pkg::BG_GOLDEN_RESET - 16'd1, 1'b1);
		put_pair(awbg_pkg::RG_GOLDEN_RESET, awbg_pkg::BG_GOLDEN_RESET - 16'd1, 1'b1);
		put_pair(awbg_pkg::RG_GOLDEN_RESET - 16'd1, awbg_pkg::BG_GOLDEN_RESET, 1'b1);
		// tie goes to red
		put_pair(awbg_pkg::RG_GOLDEN_RESET, awbg_pkg::BG_GOLDEN_RESET, 1'b1);
		// blue gain below unity
		put_pair(awbg_pkg::RG_GOLDEN_RESET, awbg_pkg::BG_GOLDEN_RESET + 16'd1, 1'b1);
		put_pair(16'hFFFF, 16'hFFFF, 1'b1);     // green gain above 4095
		put_pair(16'hFFFF, 16'd1, 1'b1);
		put_pair(16'd1, 16'hFFFF, 1'b1);
		put_pair(16'd1000, 16'd700, 1'b1);      // red candidate wins
		put_pair(16'd700, 16'd1000, 1'b1);      // blue candidate wins
		put_pair(16'hAAAA, 16'h5555, 1'b1);
		put_pair(16'h5555, 16'hAAAA, 1'b1);

		// Long result hold-off while the sender keeps offering
		press_req <= 1'b1;
		for (n = 0; n < PRESS_ITEMS; n++) begin
			put_pair(pick_ratio(cur_rg), pick_ratio(cur_bg), 1'b0);
		end
		for (n = 0; n < PER_PHASE - PRESS_ITEMS; n++) begin
			put_pair(pick_ratio(cur_rg), pick_ratio(cur_bg), 1'b1);
		end

		// Further golden settings, extremes first; last phase runs without idling
		for (phase = 1; phase < N_PHASES; phase++) begin
			settle();
			case (phase)
				1: begin
					cur_rg = 16'd1;
					cur_bg = 16'd1;
				end
				2: begin
					cur_rg = 16'hFFFF;
					cur_bg = 16'hFFFF;
				end
				3: begin
					cur_rg = 16'd1;
					cur_bg = 16'hFFFF;
				end
				4: begin
					cur_rg = 16'hFFFF;
					cur_bg = 16'd1;
				end
				5: begin
					cur_rg = awbg_pkg::RATIO_W'($urandom_range(1, 4095));
					cur_bg = awbg_pkg::RATIO_W'($urandom_range(1, 4095));
				end
				6: begin
					cur_rg = awbg_pkg::RATIO_W'($urandom_range(1, 65535));
					cur_bg = awbg_pkg::RATIO_W'($urandom_range(1, 65535));
				end
				default: begin
					cur_rg = awbg_pkg::RG_GOLDEN_RESET;
					cur_bg = awbg_pkg::BG_GOLDEN_RESET;
				end
			endcase
			if (phase == N_PHASES - 1) begin
				no_idle <= 1'b1;
			end
			cfg_we <= 1'b1;
			cfg_index <= awbg_pkg::REG_RG_GOLDEN;
			cfg_data <= cur_rg;
			@(posedge clk);
			cfg_index <= awbg_pkg::REG_BG_GOLDEN;
			cfg_data <= cur_bg;
			@(posedge clk);
			cfg_we <= 1'b0;
			for (n = 0; n < PER_PHASE; n++) begin
				put_pair(pick_ratio(cur_rg), pick_ratio(cur_bg), 1'b1);
			end
		end
		settle();

		if (gain_errors == 0 && gains_pending == 0) begin
			$display("[awb_gain_from_otp_ratios_unit] OK");
		end else begin
			$display("[awb_gain_from_otp_ratios_unit] ERROR");
		end
		$finish;
	end

endmodule

// File: awb_gain_from_otp_ratios_unit.f
sv/awbg_pkg.sv
sv/awb_gain_from_otp_ratios_unit.sv
tb/awbg_checker.sv
tb/testbench.sv
